// ===== rtl/dro_pkg.sv =====
// shared types and constants for the depth region occupancy detector
`default_nettype none

package dro_pkg;

    localparam int DRO_REGION_PIXELS = 4096;

    localparam int PIX_W      = 12;
    localparam int DEPTH_W    = 16;
    localparam int COUNT_W    = 13;
    localparam int TOTAL_W    = 16;
    localparam int PVAL_W     = 8;
    localparam int IDX_EXT_W  = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PVAL_W-1:0]  BYTE_MASK = 8'hff;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1fff;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hffff;

    localparam logic [DEPTH_W-1:0] PICKUP_DEPTH_RST = 16'd50;
    localparam logic [DEPTH_W-1:0] RETURN_DEPTH_RST = 16'd20;
    localparam logic [COUNT_W-1:0] PICKUP_COUNT_RST = 13'd2048;
    localparam logic [COUNT_W-1:0] RETURN_COUNT_RST = 13'd2048;

    typedef enum logic {
        CMD_CAPTURE = 1'b0,
        CMD_MEASURE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PICKUP_DEPTH = 2'd0,
        CFG_RETURN_DEPTH = 2'd1,
        CFG_PICKUP_COUNT = 2'd2,
        CFG_RETURN_COUNT = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/dro_bg_ram.sv =====
// background depth store: single-port-write, registered-read memory
`default_nettype none

module dro_bg_ram
    import dro_pkg::*;
#(
    parameter int DEPTH  = DRO_REGION_PIXELS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [DEPTH_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic      [DEPTH_W-1:0] rd_data
);

    logic [DEPTH_W-1:0] mem [DEPTH];
    logic [DEPTH_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/depth_region_occupancy_detector_core.sv =====
// top level: background store, compare stage, frame decision and output register
// an accepted beat passes the compare stage and the output register to the m_ side
// throughput: one beat per cycle unless m_ready stalls; the memory read is the only
// pipeline stage before the compare, and each pixel reads one entry once
// reset (aresetn low, synchronous): thresholds return to defaults, in-use flag,
// use counter and running count clear; background memory is not cleared
`default_nettype none

module depth_region_occupancy_detector_core
    import dro_pkg::*;
#(
    parameter int REGION_PIXELS = DRO_REGION_PIXELS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_command,
    input  wire logic [PIX_W-1:0]      s_pixel_index,
    input  wire logic [DEPTH_W-1:0]    s_depth_sample,
    input  wire logic                  s_last_pixel,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PVAL_W-1:0]          m_process_value,
    output logic                       m_in_use,
    output logic                       m_state_changed,
    output logic [TOTAL_W-1:0]         m_use_count,
    output logic                       m_frame_done
);

    localparam int ADDR_W = (REGION_PIXELS > 1) ? $clog2(REGION_PIXELS) : 1;

    // configuration registers
    logic [DEPTH_W-1:0] pickup_depth_reg;
    logic [DEPTH_W-1:0] return_depth_reg;
    logic [COUNT_W-1:0] pickup_count_reg;
    logic [COUNT_W-1:0] return_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pickup_depth_reg <= PICKUP_DEPTH_RST;
            return_depth_reg <= RETURN_DEPTH_RST;
            pickup_count_reg <= PICKUP_COUNT_RST;
            return_count_reg <= RETURN_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PICKUP_DEPTH: pickup_depth_reg <= cfg_wdata;
                CFG_RETURN_DEPTH: return_depth_reg <= cfg_wdata;
                CFG_PICKUP_COUNT: pickup_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_RETURN_COUNT: return_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input side and memory access
    logic                 s_fire;
    logic                 s1_valid_reg;
    logic                 s1_fire;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic                 idx_in_range;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 is_measure_in;
    logic [DEPTH_W-1:0]   bg_rd_data;

    assign s_fire        = s_valid && s_ready;
    assign idx_ext       = IDX_EXT_W'(s_pixel_index);
    assign idx_in_range  = idx_ext < IDX_EXT_W'(REGION_PIXELS);
    assign mem_addr      = idx_ext[ADDR_W-1:0];
    assign is_measure_in = (cmd_t'(s_command) == CMD_MEASURE);

    // capture writes at accept, so any measure accepted after it already sees it
    dro_bg_ram #(
        .DEPTH  (REGION_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_bg_ram (
        .aclk    (aclk),
        .wr_en   (s_fire && !is_measure_in && idx_in_range),
        .wr_addr (mem_addr),
        .wr_data (s_depth_sample),
        .rd_en   (s_fire && is_measure_in && idx_in_range),
        .rd_addr (mem_addr),
        .rd_data (bg_rd_data)
    );

    // compare stage
    logic               s1_measure_reg;
    logic [DEPTH_W-1:0] s1_depth_reg;
    logic               s1_last_reg;
    logic               s1_in_range_reg;

    logic               out_valid_reg;

    assign s1_fire = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_measure_reg  <= is_measure_in;
            s1_depth_reg    <= s_depth_sample;
            s1_last_reg     <= s_last_pixel;
            s1_in_range_reg <= idx_in_range;
        end
    end

    // detector state
    logic               item_taken_reg,  item_taken_next;
    logic [TOTAL_W-1:0] use_count_reg,   use_count_next;
    logic [COUNT_W-1:0] run_count_reg,   run_count_next;

    logic [DEPTH_W-1:0]   bg;
    logic signed [16:0]   diff;
    logic signed [16:0]   mag;
    logic                 depth_nz;
    logic                 counted;
    logic [COUNT_W-1:0]   count_upd;
    logic [COUNT_W-1:0]   count_thr;
    logic                 toggle;
    logic [PVAL_W-1:0]    pval;
    logic                 frame_end;

    always_comb begin
        bg        = s1_in_range_reg ? bg_rd_data : '0;
        diff      = $signed({1'b0, s1_depth_reg}) - $signed({1'b0, bg});
        mag       = diff[16] ? -diff : diff;
        depth_nz  = (s1_depth_reg != '0);
        if (item_taken_reg) begin
            counted = depth_nz && (mag < $signed({1'b0, return_depth_reg}));
            pval    = mag[PVAL_W-1:0] & BYTE_MASK;
        end else begin
            counted = depth_nz && (diff > $signed({1'b0, pickup_depth_reg}));
            pval    = diff[PVAL_W-1:0] & BYTE_MASK;
        end
        counted   = counted && s1_measure_reg;
        if (!counted) begin
            pval = '0;
        end

        count_upd = (counted && run_count_reg != COUNT_MAX) ? run_count_reg + 1'b1
                                                           : run_count_reg;
        count_thr = item_taken_reg ? return_count_reg : pickup_count_reg;
        frame_end = s1_measure_reg && s1_last_reg;
        toggle    = frame_end && (count_upd > count_thr);

        item_taken_next = item_taken_reg ^ toggle;
        use_count_next  = use_count_reg;
        if (toggle && !item_taken_reg && use_count_reg != TOTAL_MAX) begin
            use_count_next = use_count_reg + 1'b1;
        end
        run_count_next  = frame_end ? '0 : count_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_taken_reg <= 1'b0;
            use_count_reg  <= '0;
            run_count_reg  <= '0;
        end else if (s1_fire) begin
            item_taken_reg <= item_taken_next;
            use_count_reg  <= use_count_next;
            run_count_reg  <= run_count_next;
        end
    end

    // output register
    logic [PVAL_W-1:0]  out_pval_reg;
    logic               out_in_use_reg;
    logic               out_changed_reg;
    logic [TOTAL_W-1:0] out_use_count_reg;
    logic               out_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            out_pval_reg      <= pval;
            out_in_use_reg    <= item_taken_next;
            out_changed_reg   <= toggle;
            out_use_count_reg <= use_count_next;
            out_done_reg      <= frame_end;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_process_value = out_pval_reg;
    assign m_in_use        = out_in_use_reg;
    assign m_state_changed = out_changed_reg;
    assign m_use_count     = out_use_count_reg;
    assign m_frame_done    = out_done_reg;

`ifndef SYNTHESIS
    // a toggle only ever happens on a beat that closes a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_state_changed |-> m_frame_done)
        else $error("state change without frame end");

    // use counter moves only on a present-to-taken transition
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire && (use_count_next != use_count_reg) |-> item_taken_next && !item_taken_reg)
        else $error("use counter moved without pickup");

    // running count is cleared after a measured frame closes
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire && frame_end |=> run_count_reg == '0)
        else $error("running count not cleared at frame end");

    // input stalls only when the output register is full and not drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without output back-pressure");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for the depth region occupancy detector: queued driver, predictor and result checker
`default_nettype none

module tb;
    import dro_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cmd_t               cmd;
        logic [PIX_W-1:0]   idx;
        logic [DEPTH_W-1:0] depth;
        logic               last;
    } pixel_beat_t;

    typedef struct {
        logic [PVAL_W-1:0]  pval;
        logic               in_use;
        logic               changed;
        logic [TOTAL_W-1:0] uses;
        logic               done;
    } occ_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_command = 1'b0;
    logic [PIX_W-1:0]      s_pixel_index = '0;
    logic [DEPTH_W-1:0]    s_depth_sample = '0;
    logic                  s_last_pixel = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PVAL_W-1:0]     m_process_value;
    logic                  m_in_use;
    logic                  m_state_changed;
    logic [TOTAL_W-1:0]    m_use_count;
    logic                  m_frame_done;

    depth_region_occupancy_detector_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_pixel_index   (s_pixel_index),
        .s_depth_sample  (s_depth_sample),
        .s_last_pixel    (s_last_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_process_value (m_process_value),
        .m_in_use        (m_in_use),
        .m_state_changed (m_state_changed),
        .m_use_count     (m_use_count),
        .m_frame_done    (m_frame_done)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    // occupancy state as the block should hold it
    logic [DEPTH_W-1:0] bg_mem [DRO_REGION_PIXELS];
    logic               item_taken = 1'b0;
    logic [TOTAL_W-1:0] use_total = '0;
    logic [COUNT_W-1:0] run_cnt = '0;
    logic [DEPTH_W-1:0] pick_depth_thr = PICKUP_DEPTH_RST;
    logic [DEPTH_W-1:0] ret_depth_thr = RETURN_DEPTH_RST;
    logic [COUNT_W-1:0] pick_cnt_thr = PICKUP_COUNT_RST;
    logic [COUNT_W-1:0] ret_cnt_thr = RETURN_COUNT_RST;

    // stimulus side view of the background, to aim depths near it
    int gen_bg [DRO_REGION_PIXELS];
    bit written [DRO_REGION_PIXELS];
    int written_list [$];

    pixel_beat_t pending [$];
    occ_result_t expected_results [$];
    pixel_beat_t next_beat;
    int          items_pushed = 0;
    int          items_accepted = 0;
    int          err_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        beat_taken = 1'b0;

    function automatic occ_result_t occupancy_step(pixel_beat_t b);
        occ_result_t        r;
        int                 bg;
        int                 dv;
        int                 diff;
        int                 mag;
        bit                 hit;
        logic [COUNT_W-1:0] thr;
        r.pval = '0;
        r.changed = 1'b0;
        r.done = 1'b0;
        if (b.cmd == CMD_CAPTURE) begin
            bg_mem[b.idx] = b.depth;
        end else begin
            bg = bg_mem[b.idx];
            dv = b.depth;
            diff = dv - bg;
            if (item_taken) begin
                mag = (diff < 0) ? -diff : diff;
                hit = (dv > 0) && (mag < int'(ret_depth_thr));
                if (hit) r.pval = mag[PVAL_W-1:0];
            end else begin
                hit = (dv > 0) && (diff > int'(pick_depth_thr));
                if (hit) r.pval = diff[PVAL_W-1:0];
            end
            if (hit && run_cnt != COUNT_MAX) run_cnt++;
            if (b.last) begin
                thr = item_taken ? ret_cnt_thr : pick_cnt_thr;
                if (run_cnt > thr) begin
                    r.changed = 1'b1;
                    if (item_taken) begin
                        item_taken = 1'b0;
                    end else begin
                        item_taken = 1'b1;
                        if (use_total != TOTAL_MAX) use_total++;
                    end
                end
                run_cnt = '0;
                r.done = 1'b1;
            end
        end
        r.in_use = item_taken;
        r.uses = use_total;
        return r;
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // driver: accept side at the rising edge, payload changes at the falling edge
    always @(posedge aclk) begin
        pixel_beat_t b;
        beat_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            b.cmd = cmd_t'(s_command);
            b.idx = s_pixel_index;
            b.depth = s_depth_sample;
            b.last = s_last_pixel;
            expected_results.push_back(occupancy_step(b));
            items_accepted++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || beat_taken) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_beat = pending.pop_front();
                s_valid <= 1'b1;
                s_command <= next_beat.cmd;
                s_pixel_index <= next_beat.idx;
                s_depth_sample <= next_beat.depth;
                s_last_pixel <= next_beat.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        occ_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                w = expected_results.pop_front();
                if (m_process_value !== w.pval)
                    report($sformatf("process_value %0h want %0h", m_process_value, w.pval));
                if (m_in_use !== w.in_use)
                    report($sformatf("in_use %0b want %0b", m_in_use, w.in_use));
                if (m_state_changed !== w.changed)
                    report($sformatf("state_changed %0b want %0b", m_state_changed, w.changed));
                if (m_use_count !== w.uses)
                    report($sformatf("use_count %0d want %0d", m_use_count, w.uses));
                if (m_frame_done !== w.done)
                    report($sformatf("frame_done %0b want %0b", m_frame_done, w.done));
            end
        end
    end

    function automatic void push_beat(cmd_t c, int ix, int dep, bit last);
        pixel_beat_t b;
        b.cmd = c;
        b.idx = ix[PIX_W-1:0];
        b.depth = dep[DEPTH_W-1:0];
        b.last = last;
        pending.push_back(b);
        items_pushed++;
        if (c == CMD_CAPTURE) begin
            gen_bg[ix] = dep;
            if (!written[ix]) begin
                written[ix] = 1'b1;
                written_list.push_back(ix);
            end
        end
    endfunction

    task automatic write_reg(cfg_idx_t ri, logic [CFG_DATA_W-1:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= ri;
        cfg_wdata <= v;
        case (ri)
            CFG_PICKUP_DEPTH: pick_depth_thr = v;
            CFG_RETURN_DEPTH: ret_depth_thr = v;
            CFG_PICKUP_COUNT: pick_cnt_thr = v[COUNT_W-1:0];
            CFG_RETURN_COUNT: ret_cnt_thr = v[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (items_accepted != items_pushed || expected_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_depth_setting();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return CFG_DATA_W'($urandom_range(300));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count_setting();
        if ($urandom_range(3) != 0) return CFG_DATA_W'($urandom_range(9));
        case ($urandom_range(3))
            0: return '0;
            1: return CFG_DATA_W'(COUNT_MAX);
            2: return 16'd4096;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic random_settings();
        write_reg(CFG_PICKUP_DEPTH, pick_depth_setting());
        write_reg(CFG_RETURN_DEPTH, pick_depth_setting());
        write_reg(CFG_PICKUP_COUNT, pick_count_setting());
        write_reg(CFG_RETURN_COUNT, pick_count_setting());
    endtask

    // live depth aimed around the background and one of the two depth thresholds, picked at random
    function automatic int near_depth(int bg);
        int thr;
        int d;
        thr = $urandom_range(1) ? int'(pick_depth_thr) : int'(ret_depth_thr);
        case ($urandom_range(9))
            0: d = 0;
            1: d = $urandom_range(65535);
            2, 3, 4, 5: begin
                d = thr + $urandom_range(4) - 2;
                d = $urandom_range(1) ? bg + d : bg - d;
            end
            default: d = bg + $urandom_range(80) - 40;
        endcase
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        return d;
    endfunction

    function automatic int pick_written();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    function automatic void gen_random(int n);
        int made;
        int r;
        int len;
        int k;
        int ix;
        made = 0;
        while (made < n) begin
            r = $urandom_range(99);
            if (r < 10) begin
                push_beat(CMD_CAPTURE, $urandom_range(4095), $urandom_range(65535),
                          ($urandom_range(1) == 1));
                made++;
            end else if (r < 15) begin
                ix = pick_written();
                push_beat(CMD_MEASURE, ix, near_depth(gen_bg[ix]),
                          ($urandom_range(1) == 1));
                made++;
            end else begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++) begin
                    // a capture landing inside a frame
                    if ($urandom_range(19) == 0) begin
                        push_beat(CMD_CAPTURE, $urandom_range(4095), $urandom_range(65535),
                                  ($urandom_range(1) == 1));
                        made++;
                    end
                    ix = pick_written();
                    push_beat(CMD_MEASURE, ix, near_depth(gen_bg[ix]), k == len - 1);
                    made++;
                end
            end
        end
    endfunction

    initial begin
        int p;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset thresholds, extremes of depth and index
        push_beat(CMD_CAPTURE, 0, 0, 1'b1);
        push_beat(CMD_CAPTURE, 4095, 65535, 1'b0);
        push_beat(CMD_CAPTURE, 1, 100, 1'b0);
        push_beat(CMD_CAPTURE, 2, 1000, 1'b1);
        push_beat(CMD_MEASURE, 0, 0, 1'b0);
        push_beat(CMD_MEASURE, 0, 65535, 1'b0);
        push_beat(CMD_MEASURE, 4095, 0, 1'b0);
        push_beat(CMD_MEASURE, 4095, 1, 1'b0);
        push_beat(CMD_MEASURE, 1, 151, 1'b0);
        push_beat(CMD_MEASURE, 1, 150, 1'b0);
        push_beat(CMD_MEASURE, 2, 1300, 1'b1);
        wait_idle();

        // pickup and return on single counted pixels
        write_reg(CFG_PICKUP_DEPTH, '0);
        write_reg(CFG_RETURN_DEPTH, '1);
        write_reg(CFG_PICKUP_COUNT, '0);
        write_reg(CFG_RETURN_COUNT, '0);
        push_beat(CMD_MEASURE, 1, 101, 1'b1);
        push_beat(CMD_MEASURE, 1, 100, 1'b0);
        push_beat(CMD_MEASURE, 2, 0, 1'b0);
        push_beat(CMD_MEASURE, 4095, 1, 1'b1);
        push_beat(CMD_CAPTURE, 3, 65535, 1'b1);
        push_beat(CMD_MEASURE, 0, 65535, 1'b1);
        wait_idle();

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 48; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 48; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            random_settings();
            gen_random(80);
            // sender holds off until the pipeline has drained
            wait_idle();
            gen_random(80);
            wait_idle();
        end

        send_idle_pct = 29;
        recv_stall_pct = 29;
        random_settings();
        gen_random(40);
        wait_idle();

        repeat (10) @(posedge aclk);
        if (err_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire
